// ===== rtl/lwca_pkg.sv =====
// Shared types, constants and register codes for the weighted current average block.
package lwca_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int MAX_NEURONS_DEF = 1024;
   localparam int SUM_W           = 64;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int TOTAL_W         = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAK_CONDUCTANCE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REST_POTENTIAL   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXC_REVERSAL     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INH_REVERSAL     = 3'd4;

   localparam logic [1:0] MODE_TOTAL = 2'd0;
   localparam logic [1:0] MODE_LEAK  = 2'd1;
   localparam logic [1:0] MODE_EXC   = 2'd2;
   localparam logic [1:0] MODE_INH   = 2'd3;

   localparam logic [30:0] LEAK_CONDUCTANCE_RST = 31'd3277;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [31:0]      LFP_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0]      LFP_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [1:0]         current_mode;
      logic [30:0]        leak_conductance;
      logic signed [31:0] rest_potential;
      logic signed [31:0] exc_reversal;
      logic signed [31:0] inh_reversal;
   } lwca_cfg_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_OUT
   } lwca_div_state_type;

endpackage

// ===== rtl/lwca_req_if.sv =====
// Request channel: one neuron sample per request.
interface lwca_req_if import lwca_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [31:0] voltage;
   logic [30:0]        exc_conductance;
   logic [30:0]        inh_conductance;
   logic [30:0]        weight;
   logic               last_neuron;

   modport source (output valid, voltage, exc_conductance, inh_conductance, weight,
                   last_neuron, input ready);
   modport sink   (input valid, voltage, exc_conductance, inh_conductance, weight,
                   last_neuron, output ready);
endinterface

// ===== rtl/lwca_rsp_if.sv =====
// Response channel: averaged weighted current of one time step.
interface lwca_rsp_if import lwca_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [31:0] lfp_value;
   logic [TOTAL_W-1:0] neuron_total;

   modport source (output valid, lfp_value, neuron_total, input ready);
   modport sink   (input valid, lfp_value, neuron_total, output ready);
endinterface

// ===== rtl/lfp_weighted_current_average_core.sv =====
// Top level of the weighted current average block: registers, front, queue and back.
//
//   channel   role     handshake        payload
//   req_ch    sink     valid/ready      voltage, exc/inh_conductance, weight, last_neuron
//   rsp_ch    source   valid/ready      lfp_value, neuron_total
//   csr_*     sink     csr_we           csr_index, csr_wdata
//
// The front takes one request per cycle, unless a full queue stalls it, through a
// three-stage multiply pipeline; a step's sum and count go to the queue when its last
// request reaches stage 3. The back divides each step total bit-serially, one at a time.
// Reset clears accumulator, count, queue, pipeline valid bits; registers get defaults.
// A full queue stalls the front only when a last request reaches the accumulator.
module lfp_weighted_current_average_core import lwca_pkg::*; #(
   parameter int MAX_NEURONS = MAX_NEURONS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   lwca_req_if.sink               req_ch,
   lwca_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W = $clog2(MAX_NEURONS + 1);
   localparam int Q_W   = SUM_W + CNT_W;

   lwca_cfg_type cfg_ff, cfg_in;

   logic                    push_valid, push_ready;
   logic signed [SUM_W-1:0] push_sum;
   logic [CNT_W-1:0]        push_count;
   logic                    pop_valid, pop_ready;
   logic [Q_W-1:0]          pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CURRENT_MODE:     cfg_in.current_mode     = csr_wdata[1:0];
            CSR_LEAK_CONDUCTANCE: cfg_in.leak_conductance = csr_wdata[30:0];
            CSR_REST_POTENTIAL:   cfg_in.rest_potential   = $signed(csr_wdata);
            CSR_EXC_REVERSAL:     cfg_in.exc_reversal     = $signed(csr_wdata);
            CSR_INH_REVERSAL:     cfg_in.inh_reversal     = $signed(csr_wdata);
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.current_mode     <= MODE_TOTAL;
         cfg_ff.leak_conductance <= LEAK_CONDUCTANCE_RST;
         cfg_ff.rest_potential   <= '0;
         cfg_ff.exc_reversal     <= '0;
         cfg_ff.inh_reversal     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lwca_front #(
      .MAX_NEURONS (MAX_NEURONS),
      .CNT_W       (CNT_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_sum   (push_sum),
      .push_count (push_count)
   );

   lwca_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_sum, push_count}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   lwca_back #(
      .MAX_NEURONS (MAX_NEURONS),
      .CNT_W       (CNT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_sum   ($signed(pop_data[Q_W-1:CNT_W])),
      .pop_count (pop_data[CNT_W-1:0]),
      .rsp       (rsp_ch)
   );

endmodule

// ===== rtl/lwca_front.sv =====
// Front part: current terms, weighting and saturating accumulation per request.
module lwca_front import lwca_pkg::*; #(
   parameter int MAX_NEURONS = MAX_NEURONS_DEF,
   parameter int CNT_W       = $clog2(MAX_NEURONS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lwca_cfg_type            cfg,
   lwca_req_if.sink                req,
   output logic                    push_valid,
   input  logic                    push_ready,
   output logic signed [SUM_W-1:0] push_sum,
   output logic [CNT_W-1:0]        push_count
);

   logic advance;

   // stage 1: raw conductance products
   logic               s1_valid_ff, s1_valid_in;
   logic signed [63:0] s1_pl_ff, s1_pe_ff, s1_pi_ff;
   logic [30:0]        s1_w_ff;
   logic               s1_last_ff;

   // stage 2: saturated current
   logic               s2_valid_ff;
   logic signed [31:0] s2_cur_ff, s2_cur_in;
   logic [30:0]        s2_w_ff;
   logic               s2_last_ff;

   // stage 3: weighted current product
   logic               s3_valid_ff;
   logic signed [63:0] s3_prod_ff, s3_prod_in;
   logic               s3_last_ff;

   // accumulator
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic signed [32:0] d_leak, d_exc, d_inh;
   logic signed [64:0] p_leak, p_exc, p_inh;
   logic signed [63:0] t_leak, t_exc, t_inh;
   logic signed [65:0] cur_sum;
   logic               use_leak, use_exc, use_inh;
   logic signed [63:0] wc;
   logic signed [SUM_W:0] sum_ext;
   logic signed [SUM_W-1:0] sum_sat, sum_item;
   logic [CNT_W-1:0]   count_item;
   logic               room;

   assign push_valid  = s3_valid_ff && s3_last_ff;
   assign advance     = !push_valid || push_ready;
   assign req.ready   = advance;
   assign s1_valid_in = req.valid;

   always_comb begin
      d_leak = 33'(cfg.rest_potential) - 33'(req.voltage);
      d_exc  = 33'(cfg.exc_reversal) - 33'(req.voltage);
      d_inh  = 33'(cfg.inh_reversal) - 33'(req.voltage);
      p_leak = $signed({1'b0, cfg.leak_conductance}) * d_leak;
      p_exc  = $signed({1'b0, req.exc_conductance}) * d_exc;
      p_inh  = $signed({1'b0, req.inh_conductance}) * d_inh;
   end

   always_comb begin
      use_leak = (cfg.current_mode == MODE_TOTAL) || (cfg.current_mode == MODE_LEAK);
      use_exc  = (cfg.current_mode == MODE_TOTAL) || (cfg.current_mode == MODE_EXC);
      use_inh  = (cfg.current_mode == MODE_TOTAL) || (cfg.current_mode == MODE_INH);
      t_leak   = s1_pl_ff >>> FRAC_BITS;
      t_exc    = s1_pe_ff >>> FRAC_BITS;
      t_inh    = s1_pi_ff >>> FRAC_BITS;
      cur_sum  = '0;
      if (use_leak) begin
         cur_sum = cur_sum + 66'(t_leak);
      end
      if (use_exc) begin
         cur_sum = cur_sum + 66'(t_exc);
      end
      if (use_inh) begin
         cur_sum = cur_sum + 66'(t_inh);
      end
      if (cur_sum > 66'(LFP_MAX)) begin
         s2_cur_in = LFP_MAX;
      end else if (cur_sum < 66'(LFP_MIN)) begin
         s2_cur_in = LFP_MIN;
      end else begin
         s2_cur_in = cur_sum[31:0];
      end
   end

   assign s3_prod_in = s2_cur_ff * $signed({1'b0, s2_w_ff});

   always_comb begin
      wc      = s3_prod_ff >>> FRAC_BITS;
      sum_ext = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(wc);
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
         sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_ext[SUM_W-1:0];
      end
      room       = count_ff < CNT_W'(MAX_NEURONS);
      sum_item   = room ? sum_sat : sum_ff;
      count_item = room ? count_ff + CNT_W'(1) : count_ff;
      push_sum   = sum_item;
      push_count = count_item;
      sum_in     = sum_ff;
      count_in   = count_ff;
      if (s3_valid_ff && advance) begin
         if (s3_last_ff) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_item;
            count_in = count_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         if (advance) begin
            s1_valid_ff <= s1_valid_in;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pl_ff   <= p_leak[63:0];
         s1_pe_ff   <= p_exc[63:0];
         s1_pi_ff   <= p_inh[63:0];
         s1_w_ff    <= req.weight;
         s1_last_ff <= req.last_neuron;
         s2_cur_ff  <= s2_cur_in;
         s2_w_ff    <= s1_w_ff;
         s2_last_ff <= s1_last_ff;
         s3_prod_ff <= s3_prod_in;
         s3_last_ff <= s2_last_ff;
      end
   end

endmodule

// ===== rtl/lwca_queue.sv =====
// Short queue of finished step totals between front and back parts.
module lwca_queue import lwca_pkg::*; #(
   parameter int WIDTH = SUM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = fill_ff != FILL_W'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/lwca_back.sv =====
// Back part: bit-serial division of the step total by the neuron count.
module lwca_back import lwca_pkg::*; #(
   parameter int MAX_NEURONS = MAX_NEURONS_DEF,
   parameter int CNT_W       = $clog2(MAX_NEURONS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  logic signed [SUM_W-1:0] pop_sum,
   input  logic [CNT_W-1:0]        pop_count,
   lwca_rsp_if.source              rsp
);

   localparam int STEP_W = $clog2(SUM_W);

   lwca_div_state_type state_ff, state_in;
   logic [SUM_W-1:0]   mag_ff, mag_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   div_ff, div_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] lfp_ff, lfp_in;

   logic [CNT_W:0]     trial;
   logic               qbit;
   logic [SUM_W-1:0]   quot;

   assign rsp.valid        = state_ff == DIV_OUT;
   assign rsp.lfp_value    = lfp_ff;
   assign rsp.neuron_total = TOTAL_W'(div_ff);

   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      step_in   = step_ff;
      neg_in    = neg_ff;
      lfp_in    = lfp_ff;
      pop_ready = 1'b0;
      trial     = {rem_ff, mag_ff[SUM_W-1]} - {1'b0, div_ff};
      qbit      = !trial[CNT_W];
      quot      = {mag_ff[SUM_W-2:0], qbit};
      case (state_ff)
         DIV_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               neg_in   = pop_sum[SUM_W-1];
               mag_in   = pop_sum[SUM_W-1] ? SUM_W'(-pop_sum) : SUM_W'(pop_sum);
               div_in   = pop_count;
               rem_in   = '0;
               step_in  = '0;
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            mag_in  = quot;
            rem_in  = qbit ? trial[CNT_W-1:0] : {rem_ff[CNT_W-2:0], mag_ff[SUM_W-1]};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = DIV_OUT;
               if (div_ff == '0) begin
                  lfp_in = '0;
               end else if (neg_ff) begin
                  lfp_in = (quot > SUM_W'(64'h8000_0000)) ? LFP_MIN : 32'(-quot[31:0]);
               end else begin
                  lfp_in = (quot > SUM_W'(64'h7FFF_FFFF)) ? LFP_MAX : quot[31:0];
               end
            end
         end
         DIV_OUT: begin
            if (rsp.ready) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      lfp_ff  <= lfp_in;
   end

endmodule

// ===== test/lfp_weighted_current_average_core_test.sv =====
// Self-checking testbench for the weighted current average core: predicts each step average.
module lfp_weighted_current_average_core_test;
   import lwca_pkg::*;

   localparam int DRAIN_CYCLES = 100;
   localparam int STALL_LIMIT  = 2000;
   localparam logic [30:0] G_MAX = 31'h7FFF_FFFF;

   typedef struct {
      logic signed [31:0] voltage;
      logic [30:0]        exc_g;
      logic [30:0]        inh_g;
      logic [30:0]        weight;
      logic               last;
   } neuron_sample_type;

   typedef struct {
      logic [1:0]         mode;
      logic [30:0]        leak;
      logic signed [31:0] rest;
      logic signed [31:0] exc;
      logic signed [31:0] inh;
   } lfp_settings_type;

   typedef struct {
      logic signed [31:0]  lfp;
      logic [TOTAL_W-1:0]  total;
   } step_average_type;

   class lfp_scoreboard_type;
      lfp_settings_type settings;
      longint           step_sum;
      int unsigned      step_count;
      step_average_type expected_averages[$];
      int               errors;

      function new();
         settings.mode = MODE_TOTAL;
         settings.leak = LEAK_CONDUCTANCE_RST;
         settings.rest = '0;
         settings.exc  = '0;
         settings.inh  = '0;
         step_sum      = 0;
         step_count    = 0;
         errors        = 0;
      endfunction

      function longint membrane_term(longint g, longint e, longint v);
         return (g * (e - v)) >>> FRAC_BITS;
      endfunction

      function longint clamp_word(longint x);
         if (x > longint'(LFP_MAX)) return longint'(LFP_MAX);
         if (x < longint'(LFP_MIN)) return longint'(LFP_MIN);
         return x;
      endfunction

      function int pending();
         return expected_averages.size();
      endfunction

      function void note_request(neuron_sample_type s);
         longint           v;
         longint           cur;
         longint           wc;
         longint           avg;
         step_average_type r;
         v = longint'(s.voltage);
         if (step_count < MAX_NEURONS_DEF) begin
            cur = 0;
            if (settings.mode == MODE_TOTAL || settings.mode == MODE_LEAK)
               cur += membrane_term(longint'(settings.leak), longint'(settings.rest), v);
            if (settings.mode == MODE_TOTAL || settings.mode == MODE_EXC)
               cur += membrane_term(longint'(s.exc_g), longint'(settings.exc), v);
            if (settings.mode == MODE_TOTAL || settings.mode == MODE_INH)
               cur += membrane_term(longint'(s.inh_g), longint'(settings.inh), v);
            cur = clamp_word(cur);
            wc  = (cur * longint'(s.weight)) >>> FRAC_BITS;
            if (wc > 0 && step_sum > longint'(SUM_MAX) - wc)
               step_sum = longint'(SUM_MAX);
            else if (wc < 0 && step_sum < longint'(SUM_MIN) - wc)
               step_sum = longint'(SUM_MIN);
            else
               step_sum += wc;
            step_count++;
         end
         if (s.last) begin
            avg = 0;
            if (step_count != 0)
               avg = clamp_word(step_sum / longint'(step_count));
            r.lfp   = avg[31:0];
            r.total = step_count[TOTAL_W-1:0];
            expected_averages.push_back(r);
            step_sum   = 0;
            step_count = 0;
         end
      endfunction

      task report_mismatch(string msg);
         $display("%0t: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_response(logic signed [31:0] lfp, logic [TOTAL_W-1:0] total);
         step_average_type r;
         if (expected_averages.size() == 0) begin
            report_mismatch($sformatf("response lfp %0d total %0d with no step pending",
                                      lfp, total));
         end else begin
            r = expected_averages.pop_front();
            if (lfp !== r.lfp)
               report_mismatch($sformatf("lfp_value %0d, want %0d", lfp, r.lfp));
            if (total !== r.total)
               report_mismatch($sformatf("neuron_total %0d, want %0d", total, r.total));
         end
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   gaps_on;
   int                     quiet_cycles;

   lwca_req_if req_ch ();
   lwca_rsp_if rsp_ch ();

   lfp_scoreboard_type predictor = new();

   lfp_weighted_current_average_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (req_ch.valid && req_ch.ready) begin
            neuron_sample_type s;
            s.voltage = req_ch.voltage;
            s.exc_g   = req_ch.exc_conductance;
            s.inh_g   = req_ch.inh_conductance;
            s.weight  = req_ch.weight;
            s.last    = req_ch.last_neuron;
            predictor.note_request(s);
         end
         if (rsp_ch.valid && rsp_ch.ready)
            predictor.check_response(rsp_ch.lfp_value, rsp_ch.neuron_total);
      end
   end

   initial begin
      quiet_cycles = 0;
      @(negedge clock);
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("lfp_weighted_current_average_core_test: done, errors");
      $finish;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready = !reset;
         end
      end
   end

   function automatic logic signed [31:0] pick_potential();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return LFP_MAX;
               1: return LFP_MIN;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         1, 2, 3: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] pick_conductance();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 2))
               0: return '0;
               1: return G_MAX;
               default: return 31'd1;
            endcase
         end
         1, 2, 3: return 31'($urandom_range(0, 32'h0004_0000));
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic neuron_sample_type make_sample(logic signed [31:0] v, logic [30:0] ge,
                                                     logic [30:0] gi, logic [30:0] w,
                                                     logic last);
      neuron_sample_type s;
      s.voltage = v;
      s.exc_g   = ge;
      s.inh_g   = gi;
      s.weight  = w;
      s.last    = last;
      return s;
   endfunction

   function automatic lfp_settings_type make_settings(logic [1:0] mode, logic [30:0] leak,
                                                      logic signed [31:0] rest,
                                                      logic signed [31:0] exc,
                                                      logic signed [31:0] inh);
      lfp_settings_type c;
      c.mode = mode;
      c.leak = leak;
      c.rest = rest;
      c.exc  = exc;
      c.inh  = inh;
      return c;
   endfunction

   task automatic send_sample(neuron_sample_type s);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 11) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid           = 1'b1;
      req_ch.voltage         = s.voltage;
      req_ch.exc_conductance = s.exc_g;
      req_ch.inh_conductance = s.inh_g;
      req_ch.weight          = s.weight;
      req_ch.last_neuron     = s.last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
   endtask

   task automatic apply_settings(lfp_settings_type c);
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (predictor.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_register(CSR_CURRENT_MODE, {30'd0, c.mode});
      write_register(CSR_LEAK_CONDUCTANCE, {1'b0, c.leak});
      write_register(CSR_REST_POTENTIAL, c.rest);
      write_register(CSR_EXC_REVERSAL, c.exc);
      write_register(CSR_INH_REVERSAL, c.inh);
      @(negedge clock);
      csr_we = 1'b0;
      predictor.settings = c;
   endtask

   task automatic send_step(int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         send_sample(make_sample(pick_potential(), pick_conductance(), pick_conductance(),
                                 pick_conductance(), i == len - 1));
   endtask

   task automatic run_random_phase(int unsigned quota);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < quota) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         send_step(len);
         sent += len;
      end
   endtask

   initial begin
      reset                  = 1'b1;
      gaps_on                = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = '0;
      csr_wdata              = '0;
      req_ch.valid           = 1'b0;
      req_ch.voltage         = '0;
      req_ch.exc_conductance = '0;
      req_ch.inh_conductance = '0;
      req_ch.weight          = '0;
      req_ch.last_neuron     = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings
      send_sample(make_sample(32'sd0, '0, '0, '0, 1'b1));
      send_sample(make_sample(LFP_MAX, G_MAX, G_MAX, G_MAX, 1'b0));
      send_sample(make_sample(LFP_MIN, G_MAX, '0, G_MAX, 1'b0));
      send_sample(make_sample(-32'sd327680, 31'h10000, 31'h20000, 31'h10000, 1'b1));

      apply_settings(make_settings(MODE_EXC, G_MAX, LFP_MIN, LFP_MAX, LFP_MIN));
      send_sample(make_sample(LFP_MIN, G_MAX, G_MAX, G_MAX, 1'b1));
      send_sample(make_sample(32'sd0, 31'd1, '0, 31'h10000, 1'b0));
      send_sample(make_sample(LFP_MAX, '0, G_MAX, 31'd1, 1'b1));

      apply_settings(make_settings(MODE_INH, '0, LFP_MAX, LFP_MIN, LFP_MIN));
      send_sample(make_sample(LFP_MAX, G_MAX, G_MAX, G_MAX, 1'b1));
      send_sample(make_sample(-32'sd1, 31'h1234_5678, 31'h10000, 31'h8000, 1'b1));

      apply_settings(make_settings(MODE_LEAK, G_MAX, LFP_MAX, LFP_MAX, LFP_MAX));
      send_sample(make_sample(LFP_MIN, '0, '0, G_MAX, 1'b1));
      send_sample(make_sample(-32'sd1, G_MAX, G_MAX, 31'h2AAA_AAAA, 1'b0));
      send_sample(make_sample(32'sh5555_5555, 31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555,
                              1'b1));

      apply_settings(make_settings(MODE_TOTAL, LEAK_CONDUCTANCE_RST, -32'sd4259840, 32'sd0,
                                   -32'sd5242880));
      send_sample(make_sample(-32'sd4259840, 31'h0800, 31'h0400, 31'h10000, 1'b0));
      send_sample(make_sample(-32'sd3932160, 31'h1000, 31'h0000, 31'h08000, 1'b0));
      send_sample(make_sample(-32'sd4587520, 31'h0000, 31'h2000, 31'h18000, 1'b0));
      send_sample(make_sample(32'sd1310720, 31'h4000, 31'h1000, 31'h04000, 1'b1));

      for (int p = 0; p < 8; p++) begin
         gaps_on = (p < 6) && (p != 3);
         apply_settings(make_settings(2'(p % 4), pick_conductance(), pick_potential(),
                                      pick_potential(), pick_potential()));
         run_random_phase(50);
      end

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (predictor.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predictor.errors == 0)
         $display("lfp_weighted_current_average_core_test: done, clean");
      else
         $display("lfp_weighted_current_average_core_test: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lwca_pkg.sv
rtl/lwca_req_if.sv
rtl/lwca_rsp_if.sv
rtl/lwca_front.sv
rtl/lwca_queue.sv
rtl/lwca_back.sv
rtl/lfp_weighted_current_average_core.sv
test/lfp_weighted_current_average_core_test.sv
